@@ rtl/ovl_pkg.sv @@
// ovl_pkg: shared types and constants of the ordered value list
// command and status codes, field widths, transfer record between front and back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CMD_W         = 2;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 2'd0,
    CMD_DELETE    = 2'd1,
    CMD_SEARCH    = 2'd2,
    CMD_DEL_FRONT = 2'd3
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e_t;

  typedef struct packed {
    cmd_e_t             cmd;
    logic [VALUE_W-1:0] value;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/ovl_if.sv @@
// ovl_in_if / ovl_out_if: valid-ready channels of the ordered value list
// command channel carries cmd and value, result channel carries status and count
// depends on ovl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ovl_in_if import ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ovl_out_if import ovl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/ovl_front.sv @@
// ovl_front: accepts command transfers, decodes them and queues them for the back end
// two-entry queue decouples the input channel from the list sequencer
// depends on ovl_pkg, ovl_in_if
`timescale 1ns / 1ps
`default_nettype none

module ovl_front
  import ovl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ovl_in_if.sink   in_ch,
  output op_t      q_op,
  output logic     q_valid,
  input  logic     q_pop
);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  op_t              q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  op_t              dec_op;

  always_comb begin
    dec_op.cmd   = cmd_e_t'(in_ch.cmd);
    dec_op.value = in_ch.value;
  end

  assign in_ch.ready = (count != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_pop && q_valid;
  assign q_op        = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ovl_back.sv @@
// ovl_back: list cells with per-cell compare, shift-on-delete and result register
// sequencer takes one queued command, compares all cells, then applies and reports
// depends on ovl_pkg, ovl_out_if
`timescale 1ns / 1ps
`default_nettype none

module ovl_back
  import ovl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  op_t      q_op,
  input  logic     q_valid,
  output logic     q_pop,
  ovl_out_if.source out_ch
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  op_t                cur;
  logic [VALUE_W-1:0] cells [DEPTH];
  logic [VALUE_W-1:0] up_val [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [DEPTH-1:0]   vld_next;
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   shift_sel;
  logic [DEPTH-1:0]   tail_sel;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;
  logic               empty;
  logic               full;
  logic               found;
  logic               append_go;
  logic               shift_go;
  logic               apply_go;
  logic               out_free;
  status_e_t          status;
  logic               out_valid;
  status_e_t          out_status;
  logic [COUNT_W-1:0] out_count;

  assign empty    = !vld[0];
  assign full     = vld[DEPTH-1];
  assign found    = |match_vec;
  assign out_free = !out_valid || out_ch.ready;
  assign apply_go = (state == S_APPLY) && out_free;
  assign q_pop    = (state == S_IDLE) && q_valid;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_up
      assign up_val[g] = cells[g+1];
    end else begin : g_top
      assign up_val[g] = cells[g];
    end
    if (g == 0) begin : g_head
      assign tail_sel[g] = !vld[g];
    end else begin : g_rest
      assign tail_sel[g] = !vld[g] && vld[g-1];
    end
  end

  // cells at and above the first match move down one place; on delete-front every cell moves down
  always_comb begin
    if (cur.cmd == CMD_DEL_FRONT) begin
      shift_sel = '1;
    end else begin
      shift_sel = match_vec | (~match_vec + DEPTH'(1));
    end
  end

  always_comb begin
    status = ST_OK;
    unique case (cur.cmd)
      CMD_APPEND: begin
        status = full ? ST_FULL : ST_OK;
      end
      CMD_DELETE, CMD_SEARCH: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end
      end
      CMD_DEL_FRONT: begin
        status = empty ? ST_EMPTY : ST_OK;
      end
      default: status = ST_OK;
    endcase
  end

  assign append_go = (cur.cmd == CMD_APPEND) && !full;
  assign shift_go  = ((cur.cmd == CMD_DELETE) && found) ||
                     ((cur.cmd == CMD_DEL_FRONT) && !empty);

  always_comb begin
    vld_next = vld;
    occ_next = occ;
    if (append_go) begin
      vld_next = vld | tail_sel;
      occ_next = occ + OCC_W'(1);
    end else if (shift_go) begin
      vld_next = vld >> 1;
      occ_next = occ - OCC_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid) state_next = S_MATCH;
      S_MATCH: state_next = S_APPLY;
      S_APPLY: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_op;
    end
    if (state == S_MATCH) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= vld[i] && (cells[i] == cur.value);
      end
    end
    if (apply_go) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (append_go && tail_sel[i]) begin
          cells[i] <= cur.value;
        end else if (shift_go && shift_sel[i]) begin
          cells[i] <= up_val[i];
        end
      end
      out_status <= status;
      out_count  <= COUNT_W'(occ_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        vld       <= vld_next;
        occ       <= occ_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.entry_count = out_count;

  a_occ_tracks_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(occ))
    else $error("occupancy count differs from number of valid cells");

  a_vld_packed: assert property (@(posedge clk) disable iff (rst)
    (vld & (vld + DEPTH'(1))) == '0)
    else $error("valid cells are not packed toward the head");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (apply_go && status == ST_FULL) |-> full)
    else $error("full status reported with free cells");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (apply_go && shift_go) |=> (occ == $past(occ) - OCC_W'(1)))
    else $error("removal did not shrink the list by one");

  a_apply_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && !out_free) |=> (state == S_APPLY && $stable(match_vec)))
    else $error("pending command left apply while result slot busy");

endmodule

`default_nettype wire

@@ rtl/ordered_value_list_unit.sv @@
// ordered_value_list_unit: top level of the bounded insertion-ordered value list
// front end queues commands, back end holds the cells and returns one result per command
// depends on ovl_pkg, ovl_if, ovl_front, ovl_back
//
//   channel  dir  payload                        transfer when
//   in_ch    in   cmd[1:0], value[31:0]          in_ch.valid && in_ch.ready
//   out_ch   out  status[1:0], entry_count[4:0]  out_ch.valid && out_ch.ready
//
// each command passes through the back end in order: dequeue, compare against all
// cells, then apply and load the result register
// a two-entry queue takes commands while the back end works or the result waits
// reset clears the queue, cell valid bits, count and result valid; no clearing pass
// a stalled result holds the back end in apply; the queue keeps accepting until full
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list_unit
  import ovl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  ovl_in_if.sink    in_ch,
  ovl_out_if.source out_ch
);

  op_t  q_op;
  logic q_valid;
  logic q_pop;

  ovl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_op    (q_op),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  ovl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_op    (q_op),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
